// ===== hdl/dtfb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Depth-tested frame buffer package
// Shared constants, operation and status codes, and the control and status
// bundles passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package dtfb_pkg;

  localparam int MaxWidthDef  = 256;
  localparam int MaxHeightDef = 256;
  localparam int DepthBitsDef = 24;

  localparam int CfgW   = 9;
  localparam int CoordW = 16;
  localparam int ChanW  = 8;
  localparam int FragDW = 24;

  localparam logic [0:0] CfgWidth  = 1'b0;
  localparam logic [0:0] CfgHeight = 1'b1;

  typedef enum logic [1:0] {
    FUNC_WRITE     = 2'd0,
    FUNC_READ      = 2'd1,
    FUNC_CLR_COLOR = 2'd2,
    FUNC_CLR_DEPTH = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_DEPTH_FAIL = 2'd1,
    ST_OOB        = 2'd2
  } status_e;

  typedef struct packed {
    logic capture;
    logic calc;
    logic read;
    logic check;
    logic finish;
    logic sweep;
    logic init;
  } dtfb_cmd_t;

  typedef struct packed {
    logic sweep_last;
  } dtfb_stat_t;

endpackage
`default_nettype wire

// ===== hdl/depth_tested_frame_buffer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Depth-tested frame buffer
// Color and depth stores with fragment depth test, pixel read and full clears.
// ----------------------------------------------------------------------------
// Fragment writes and pixel reads: address calculation, a read of both stores,
// then the depth test and write; a new beat is taken only after the last one is
// through, set by the read-test-write order on one RAM port. Color and depth
// clears sweep every MAX_WIDTH*MAX_HEIGHT entry; after reset such a pass holds
// busy high; configuration writes are taken throughout. Results cannot be stalled.
module depth_tested_frame_buffer #(
  parameter int MAX_WIDTH  = dtfb_pkg::MaxWidthDef,
  parameter int MAX_HEIGHT = dtfb_pkg::MaxHeightDef,
  parameter int DEPTH_BITS = dtfb_pkg::DepthBitsDef
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [0:0]                         cfg_idx_i,
  input  wire logic [dtfb_pkg::CfgW-1:0]          cfg_data_i,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [1:0]                         func_i,
  input  wire logic signed [dtfb_pkg::CoordW-1:0] pixel_x_i,
  input  wire logic signed [dtfb_pkg::CoordW-1:0] pixel_y_i,
  input  wire logic [dtfb_pkg::ChanW-1:0]         color_red_i,
  input  wire logic [dtfb_pkg::ChanW-1:0]         color_green_i,
  input  wire logic [dtfb_pkg::ChanW-1:0]         color_blue_i,
  input  wire logic [dtfb_pkg::FragDW-1:0]        frag_depth_i,
  output logic                                    valid_o,
  output logic [1:0]                              status_o,
  output logic [dtfb_pkg::ChanW-1:0]              read_red_o,
  output logic [dtfb_pkg::ChanW-1:0]              read_green_o,
  output logic [dtfb_pkg::ChanW-1:0]              read_blue_o
);
  import dtfb_pkg::*;

  dtfb_cmd_t  cmd;
  dtfb_stat_t stat;

  dtfb_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .func_i (func_i),
    .busy   (busy),
    .cmd_o  (cmd),
    .stat_i (stat)
  );

  dtfb_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .func_i        (func_i),
    .pixel_x_i     (pixel_x_i),
    .pixel_y_i     (pixel_y_i),
    .color_red_i   (color_red_i),
    .color_green_i (color_green_i),
    .color_blue_i  (color_blue_i),
    .frag_depth_i  (frag_depth_i),
    .valid_o       (valid_o),
    .status_o      (status_o),
    .read_red_o    (read_red_o),
    .read_green_o  (read_green_o),
    .read_blue_o   (read_blue_o)
  );

endmodule
`default_nettype wire

// ===== hdl/dtfb_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One address per cycle, synchronous write and registered read.
// ----------------------------------------------------------------------------
module dtfb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/dtfb_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Depth-tested frame buffer controller
// Sequences the initial clearing pass, pixel accesses and full-store clears.
// ----------------------------------------------------------------------------
module dtfb_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  input  wire logic [1:0]          func_i,
  output logic                     busy,
  output dtfb_pkg::dtfb_cmd_t      cmd_o,
  input  wire dtfb_pkg::dtfb_stat_t stat_i
);
  import dtfb_pkg::*;

  typedef enum logic [5:0] {
    S_INIT  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_CALC  = 6'b000100,
    S_READ  = 6'b001000,
    S_CHECK = 6'b010000,
    S_CLEAR = 6'b100000
  } state_e;

  state_e state_q, state_d;
  func_e  func_in;

  assign func_in = func_e'(func_i);
  assign busy    = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_INIT: begin
        cmd_o.sweep = 1'b1;
        cmd_o.init  = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          if (func_in == FUNC_CLR_COLOR || func_in == FUNC_CLR_DEPTH) begin
            state_d = S_CLEAR;
          end else begin
            state_d = S_CALC;
          end
        end
      end
      S_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = S_READ;
      end
      S_READ: begin
        cmd_o.read = 1'b1;
        state_d    = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.check  = 1'b1;
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      S_CLEAR: begin
        cmd_o.sweep = 1'b1;
        if (stat_i.sweep_last) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("Accepted beat did not make the controller busy.");

  a_finish_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> (state_q == S_IDLE))
    else $error("Controller did not return to idle after a result.");

  a_read_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.read |=> cmd_o.check)
    else $error("Memory read was not followed by the check step.");

endmodule
`default_nettype wire

// ===== hdl/dtfb_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Depth-tested frame buffer datapath
// Configuration registers, address generation, color and depth stores,
// the depth test and the result register.
// ----------------------------------------------------------------------------
module dtfb_datapath #(
  parameter int MAX_WIDTH  = dtfb_pkg::MaxWidthDef,
  parameter int MAX_HEIGHT = dtfb_pkg::MaxHeightDef,
  parameter int DEPTH_BITS = dtfb_pkg::DepthBitsDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire dtfb_pkg::dtfb_cmd_t         cmd_i,
  output dtfb_pkg::dtfb_stat_t             stat_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [0:0]                  cfg_idx_i,
  input  wire logic [dtfb_pkg::CfgW-1:0]   cfg_data_i,
  input  wire logic [1:0]                  func_i,
  input  wire logic [dtfb_pkg::CoordW-1:0] pixel_x_i,
  input  wire logic [dtfb_pkg::CoordW-1:0] pixel_y_i,
  input  wire logic [dtfb_pkg::ChanW-1:0]  color_red_i,
  input  wire logic [dtfb_pkg::ChanW-1:0]  color_green_i,
  input  wire logic [dtfb_pkg::ChanW-1:0]  color_blue_i,
  input  wire logic [dtfb_pkg::FragDW-1:0] frag_depth_i,
  output logic                             valid_o,
  output logic [1:0]                       status_o,
  output logic [dtfb_pkg::ChanW-1:0]       read_red_o,
  output logic [dtfb_pkg::ChanW-1:0]       read_green_o,
  output logic [dtfb_pkg::ChanW-1:0]       read_blue_o
);
  import dtfb_pkg::*;

  localparam int StoreSize = MAX_WIDTH * MAX_HEIGHT;
  localparam int AddrW     = (StoreSize > 1) ? $clog2(StoreSize) : 1;
  localparam int ColorW    = 3 * ChanW;
  localparam int SumW      = 2 * CfgW + 1;
  localparam logic [AddrW-1:0]      LastAddr     = AddrW'(StoreSize - 1);
  localparam logic [32:0]           DepthMaxWide = (33'd1 << DEPTH_BITS) - 33'd1;
  localparam logic [DEPTH_BITS-1:0] DepthMax     = '1;

  logic [CfgW-1:0]       width_q, height_q;
  logic [CfgW-1:0]       w_eff, h_eff;
  func_e                 func_q;
  logic [CoordW-1:0]     x_q, y_q;
  logic [ColorW-1:0]     color_q;
  logic [DEPTH_BITS-1:0] depth_q;
  logic [32:0]           depth_wide, depth_sat;
  logic [AddrW-1:0]      addr_q, addr_d;
  logic                  inb_q, inb_d;
  logic [2*CfgW-1:0]     prod;
  logic [SumW-1:0]       addr_sum;
  logic [AddrW-1:0]      cnt_q;
  logic [AddrW-1:0]      mem_addr;
  logic                  color_we, depth_we, frag_we, pass;
  logic [ColorW-1:0]     color_wd, color_rd;
  logic [DEPTH_BITS-1:0] depth_wd, depth_rd;
  status_e               status_d;
  logic [ColorW-1:0]     rc_d;
  logic                  valid_q;
  status_e               status_q;
  logic [ColorW-1:0]     rc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CfgW'(256);
      height_q <= CfgW'(256);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgWidth:  width_q  <= cfg_data_i;
        CfgHeight: height_q <= cfg_data_i;
        default: begin
          width_q <= width_q;
        end
      endcase
    end
  end

  always_comb begin
    w_eff = (32'(width_q) > 32'(MAX_WIDTH)) ? CfgW'(MAX_WIDTH) : width_q;
    h_eff = (32'(height_q) > 32'(MAX_HEIGHT)) ? CfgW'(MAX_HEIGHT) : height_q;
  end

  assign depth_wide = 33'(frag_depth_i);
  assign depth_sat  = (depth_wide > DepthMaxWide) ? DepthMaxWide : depth_wide;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q  <= func_e'(func_i);
      x_q     <= pixel_x_i;
      y_q     <= pixel_y_i;
      color_q <= {color_red_i, color_green_i, color_blue_i};
      depth_q <= depth_sat[DEPTH_BITS-1:0];
    end
  end

  assign inb_d = !x_q[CoordW-1] && !y_q[CoordW-1]
              && (x_q < CoordW'(w_eff)) && (y_q < CoordW'(h_eff));
  assign prod     = y_q[CfgW-1:0] * w_eff;
  assign addr_sum = SumW'(prod) + SumW'(x_q[CfgW-1:0]);
  assign addr_d   = AddrW'(addr_sum);

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      addr_q <= addr_d;
      inb_q  <= inb_d;
    end
  end

  assign stat_o.sweep_last = (cnt_q == LastAddr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.sweep) begin
      cnt_q <= stat_o.sweep_last ? '0 : cnt_q + AddrW'(1);
    end
  end

  assign pass     = (depth_q < depth_rd);
  assign frag_we  = cmd_i.check && (func_q == FUNC_WRITE) && inb_q && pass;
  assign color_we = frag_we || (cmd_i.sweep && (cmd_i.init || func_q == FUNC_CLR_COLOR));
  assign depth_we = frag_we || (cmd_i.sweep && (cmd_i.init || func_q == FUNC_CLR_DEPTH));
  assign color_wd = cmd_i.init ? '0 : color_q;
  assign depth_wd = cmd_i.sweep ? DepthMax : depth_q;
  assign mem_addr = cmd_i.sweep ? cnt_q : addr_q;

  dtfb_ram #(
    .WIDTH (ColorW),
    .DEPTH (StoreSize)
  ) u_color_ram (
    .clk_i   (clk_i),
    .we_i    (color_we),
    .re_i    (cmd_i.read),
    .addr_i  (mem_addr),
    .wdata_i (color_wd),
    .rdata_o (color_rd)
  );

  dtfb_ram #(
    .WIDTH (DEPTH_BITS),
    .DEPTH (StoreSize)
  ) u_depth_ram (
    .clk_i   (clk_i),
    .we_i    (depth_we),
    .re_i    (cmd_i.read),
    .addr_i  (mem_addr),
    .wdata_i (depth_wd),
    .rdata_o (depth_rd)
  );

  always_comb begin
    status_d = ST_OK;
    rc_d     = '0;
    if (cmd_i.check) begin
      case (func_q)
        FUNC_WRITE: begin
          if (!inb_q) begin
            status_d = ST_OOB;
          end else if (!pass) begin
            status_d = ST_DEPTH_FAIL;
          end
        end
        FUNC_READ: begin
          if (inb_q) begin
            rc_d = color_rd;
          end else begin
            status_d = ST_OOB;
          end
        end
        default: begin
          status_d = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      status_q <= status_d;
      rc_q     <= rc_d;
    end
  end

  assign valid_o      = valid_q;
  assign status_o     = status_q;
  assign read_red_o   = rc_q[3*ChanW-1:2*ChanW];
  assign read_green_o = rc_q[2*ChanW-1:ChanW];
  assign read_blue_o  = rc_q[ChanW-1:0];

  a_frag_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.check && color_we) |-> (depth_we && inb_q))
    else $error("Fragment write did not update both stores inside the frame.");

  a_oob_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o == ST_OOB) |-> (rc_q == '0))
    else $error("Out-of-bounds beat carries nonzero color.");

  a_sweep_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.sweep && stat_o.sweep_last) |=> (cnt_q == '0))
    else $error("Sweep counter did not return to zero after the last entry.");

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth-tested frame buffer testbench
// Drives fragment writes, pixel reads and both clears through the start/busy
// handshake at several frame sizes, predicts every status and read color from
// a local copy of the color and depth stores, and checks each result beat.
// ----------------------------------------------------------------------------
module tb_top;
  import dtfb_pkg::*;

  localparam int          StoreSize  = MaxWidthDef * MaxHeightDef;
  localparam logic [23:0] DepthMax   = 24'hFF_FFFF;
  localparam int          StallLimit = 4 * StoreSize;

  typedef struct {
    status_e    status;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_result_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_we_i      = 1'b0;
  logic [0:0]         cfg_idx_i     = CfgWidth;
  logic [CfgW-1:0]    cfg_data_i    = '0;
  logic               start         = 1'b0;
  logic               busy;
  logic [1:0]         func_i        = FUNC_READ;
  logic signed [15:0] pixel_x_i     = '0;
  logic signed [15:0] pixel_y_i     = '0;
  logic [7:0]         color_red_i   = '0;
  logic [7:0]         color_green_i = '0;
  logic [7:0]         color_blue_i  = '0;
  logic [23:0]        frag_depth_i  = '0;
  logic               valid_o;
  logic [1:0]         status_o;
  logic [7:0]         read_red_o;
  logic [7:0]         read_green_o;
  logic [7:0]         read_blue_o;

  logic [23:0]   color_mem [StoreSize];
  logic [23:0]   depth_mem [StoreSize];
  logic [8:0]    frame_w = 9'd256;
  logic [8:0]    frame_h = 9'd256;
  pixel_result_t pending_results[$];

  bit no_idle     = 1'b0;
  int clears_left = 3;
  int stall_count = 0;
  int n_errors    = 0;
  int n_checked   = 0;
  int n_written   = 0;
  int n_rejected  = 0;
  int n_reads     = 0;
  int n_oob       = 0;
  int n_clears    = 0;
  int n_cfg       = 0;

  depth_tested_frame_buffer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .start        (start),
    .busy         (busy),
    .func_i       (func_i),
    .pixel_x_i    (pixel_x_i),
    .pixel_y_i    (pixel_y_i),
    .color_red_i  (color_red_i),
    .color_green_i(color_green_i),
    .color_blue_i (color_blue_i),
    .frag_depth_i (frag_depth_i),
    .valid_o      (valid_o),
    .status_o     (status_o),
    .read_red_o   (read_red_o),
    .read_green_o (read_green_o),
    .read_blue_o  (read_blue_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic int eff_dim(input logic [8:0] v, input int lim);
    return (int'(v) > lim) ? lim : int'(v);
  endfunction

  function automatic bit locate_pixel(input int x, input int y, output int idx);
    int w;
    int h;
    w   = eff_dim(frame_w, MaxWidthDef);
    h   = eff_dim(frame_h, MaxHeightDef);
    idx = 0;
    if (x < 0 || y < 0 || x >= w || y >= h) return 1'b0;
    idx = y * w + x;
    return 1'b1;
  endfunction

  task automatic apply_op(input func_e f, input logic signed [15:0] x,
                          input logic signed [15:0] y, input logic [7:0] r,
                          input logic [7:0] g, input logic [7:0] b,
                          input logic [23:0] d);
    pixel_result_t res;
    int            idx;
    bit            in_frame;
    res.status = ST_OK;
    res.red    = '0;
    res.green  = '0;
    res.blue   = '0;
    in_frame   = locate_pixel(int'(x), int'(y), idx);
    case (f)
      FUNC_WRITE: begin
        if (!in_frame) begin
          res.status = ST_OOB;
          n_oob++;
        end else if (d < depth_mem[idx]) begin
          depth_mem[idx] = d;
          color_mem[idx] = {r, g, b};
          n_written++;
        end else begin
          res.status = ST_DEPTH_FAIL;
          n_rejected++;
        end
      end
      FUNC_READ: begin
        n_reads++;
        if (in_frame) begin
          {res.red, res.green, res.blue} = color_mem[idx];
        end else begin
          res.status = ST_OOB;
          n_oob++;
        end
      end
      FUNC_CLR_COLOR: begin
        foreach (color_mem[i]) color_mem[i] = {r, g, b};
        n_clears++;
      end
      default: begin
        foreach (depth_mem[i]) depth_mem[i] = DepthMax;
        n_clears++;
      end
    endcase
    pending_results.push_back(res);
  endtask

  function automatic int pick_gap();
    int p;
    if (no_idle) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // Entered and left at a falling edge; start stays high across back-to-back beats.
  task automatic send_op(input func_e f, input logic signed [15:0] x,
                         input logic signed [15:0] y, input logic [7:0] r,
                         input logic [7:0] g, input logic [7:0] b,
                         input logic [23:0] d);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start         = 1'b1;
    func_i        = f;
    pixel_x_i     = x;
    pixel_y_i     = y;
    color_red_i   = r;
    color_green_i = g;
    color_blue_i  = b;
    frag_depth_i  = d;
    do @(posedge clk_i); while (busy);
    apply_op(f, x, y, r, g, b, d);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_frame(input int w, input int h);
    wait_idle();
    cfg_we_i   = 1'b1;
    cfg_idx_i  = CfgWidth;
    cfg_data_i = 9'(w);
    frame_w    = 9'(w);
    @(negedge clk_i);
    cfg_idx_i  = CfgHeight;
    cfg_data_i = 9'(h);
    frame_h    = 9'(h);
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    n_cfg     += 2;
  endtask

  function automatic logic signed [15:0] pick_coord(input int lim);
    int p;
    p = $urandom_range(0, 99);
    if (p < 40 && lim > 0) return 16'($urandom_range(0, ((lim < 4) ? lim : 4) - 1));
    if (p < 75 && lim > 0) return 16'($urandom_range(0, lim - 1));
    if (p < 88) begin
      case ($urandom_range(0, 3))
        0:       return -16'sd1;
        1:       return 16'(lim);
        2:       return 16'(lim - 1);
        default: return 16'sd0;
      endcase
    end
    return 16'($urandom);
  endfunction

  function automatic logic [23:0] pick_depth();
    int p;
    p = $urandom_range(0, 99);
    if (p < 8)  return DepthMax;
    if (p < 12) return DepthMax - 24'd1;
    if (p < 16) return '0;
    if (p < 50) return 24'($urandom_range(0, 255));
    return 24'($urandom);
  endfunction

  task automatic send_random_op();
    func_e              f;
    int                 p;
    logic signed [15:0] x;
    logic signed [15:0] y;
    p = $urandom_range(0, 999);
    if (clears_left > 0 && p < 4) begin
      f = (p < 2) ? FUNC_CLR_COLOR : FUNC_CLR_DEPTH;
      clears_left--;
    end else if (p < 560) begin
      f = FUNC_WRITE;
    end else begin
      f = FUNC_READ;
    end
    x = pick_coord(eff_dim(frame_w, MaxWidthDef));
    y = pick_coord(eff_dim(frame_h, MaxHeightDef));
    send_op(f, x, y, 8'($urandom), 8'($urandom), 8'($urandom), pick_depth());
  endtask

  task automatic test_reset_defaults();
    send_op(FUNC_READ,  16'sd0,      16'sd0,      8'h00, 8'h00, 8'h00, 24'h0);
    send_op(FUNC_READ,  16'sd255,    16'sd255,    8'hFF, 8'hFF, 8'hFF, DepthMax);
    send_op(FUNC_WRITE, 16'sd0,      16'sd0,      8'hFF, 8'h00, 8'h80, DepthMax);
    send_op(FUNC_WRITE, 16'sd0,      16'sd0,      8'h12, 8'h34, 8'h56, 24'h0);
    send_op(FUNC_WRITE, 16'sd0,      16'sd0,      8'hFF, 8'hFF, 8'hFF, 24'h0);
    send_op(FUNC_READ,  16'sd0,      16'sd0,      8'h00, 8'h00, 8'h00, 24'h0);
    send_op(FUNC_WRITE, 16'sd255,    16'sd255,    8'hFF, 8'hFF, 8'hFF, DepthMax - 24'd1);
    send_op(FUNC_READ,  16'sd255,    16'sd255,    8'h00, 8'h00, 8'h00, 24'h0);
    send_op(FUNC_WRITE, -16'sd1,     16'sd0,      8'h01, 8'h02, 8'h03, 24'h0);
    send_op(FUNC_WRITE, 16'sd0,      -16'sd32768, 8'h01, 8'h02, 8'h03, 24'h0);
    send_op(FUNC_READ,  16'sd256,    16'sd0,      8'h00, 8'h00, 8'h00, 24'h0);
    send_op(FUNC_READ,  16'sd0,      16'sd256,    8'h00, 8'h00, 8'h00, 24'h0);
    send_op(FUNC_READ,  16'sd32767,  16'sd32767,  8'h00, 8'h00, 8'h00, 24'h0);
    send_op(FUNC_WRITE, -16'sd32768, 16'sd32767,  8'hAA, 8'h55, 8'hAA, DepthMax);
  endtask

  task automatic test_clears();
    send_op(FUNC_CLR_COLOR, 16'sd7, -16'sd9, 8'hAA, 8'h55, 8'hFF, 24'h55AA55);
    send_op(FUNC_READ,  16'sd0,   16'sd0,   8'h00, 8'h00, 8'h00, 24'h0);
    send_op(FUNC_READ,  16'sd128, 16'sd77,  8'h00, 8'h00, 8'h00, 24'h0);
    send_op(FUNC_WRITE, 16'sd0,   16'sd0,   8'h01, 8'h01, 8'h01, 24'd5);
    send_op(FUNC_WRITE, 16'sd3,   16'sd3,   8'h01, 8'h01, 8'h01, DepthMax);
    send_op(FUNC_CLR_DEPTH, 16'sd0, 16'sd0, 8'h5A, 8'hA5, 8'h00, 24'h0);
    send_op(FUNC_WRITE, 16'sd0,   16'sd0,   8'h9C, 8'h3E, 8'h71, 24'd5);
    send_op(FUNC_READ,  16'sd0,   16'sd0,   8'h00, 8'h00, 8'h00, 24'h0);
    send_op(FUNC_CLR_COLOR, 16'sd0, 16'sd0, 8'h00, 8'h00, 8'h00, 24'h0);
    send_op(FUNC_READ,  16'sd0,   16'sd0,   8'h00, 8'h00, 8'h00, 24'h0);
  endtask

  task automatic test_frame_sizes();
    int size_w[10] = '{256, 0, 1, 511, 17, 256, 1, 8, 300, 40};
    int size_h[10] = '{256, 40, 1, 511, 5, 1, 256, 8, 3, 0};
    foreach (size_w[i]) begin
      set_frame(size_w[i], size_h[i]);
      repeat (64) send_random_op();
    end
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 4; phase++) begin
      if (phase == 3) set_frame($urandom_range(0, 511), $urandom_range(0, 511));
      else set_frame($urandom_range(1, 32), $urandom_range(1, 32));
      no_idle = (phase == 0);
      repeat (40) send_random_op();
    end
    no_idle = 1'b0;
  endtask

  always @(posedge clk_i) begin : check_results
    pixel_result_t want;
    if (rst_ni && valid_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected: status %0d rgb %02h%02h%02h",
                 $time, status_o, read_red_o, read_green_o, read_blue_o);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (status_o !== want.status || read_red_o !== want.red ||
            read_green_o !== want.green || read_blue_o !== want.blue) begin
          $display("%0t: mismatch: expected %0d %02h%02h%02h, got %0d %02h%02h%02h",
                   $time, want.status, want.red, want.green, want.blue,
                   status_o, read_red_o, read_green_o, read_blue_o);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || valid_o) begin
      stall_count <= 0;
    end else if (stall_count >= StallLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  initial begin
    foreach (color_mem[i]) begin
      color_mem[i] = '0;
      depth_mem[i] = DepthMax;
    end
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_clears();
    test_frame_sizes();
    test_random_traffic();

    wait_idle();
    repeat (8) @(posedge clk_i);
    $display("Checked %0d results: %0d writes kept, %0d lost the depth test, %0d reads.",
             n_checked, n_written, n_rejected, n_reads);
    $display("Also %0d out-of-frame beats, %0d full clears, %0d register writes.",
             n_oob, n_clears, n_cfg);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/dtfb_pkg.sv
hdl/dtfb_ram.sv
hdl/dtfb_ctrl.sv
hdl/dtfb_datapath.sv
hdl/depth_tested_frame_buffer.sv
tb/tb_top.sv
